/* rtl/core/fuzzy_norm_composition_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the fuzzy norm composition RTL
// Clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef FUZZY_NORM_COMPOSITION_MACROS_SVH
`define FUZZY_NORM_COMPOSITION_MACROS_SVH

// Check a condition on every clock edge
`define FNC_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Check that a condition implies another one on the next clock edge
`define FNC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/fnc_pkg.sv */
// ----------------------------------------------------------------------------
// fnc_pkg
// Types, constants and grade arithmetic for the fuzzy norm composition block.
// ----------------------------------------------------------------------------
package fnc_pkg;

    // Field widths and the fixed-point scale
    localparam int FIELD_CAP       = 16;
    localparam int GRADE_W         = 16;
    localparam int INDEX_W         = 4;
    localparam int ROW_W           = 16;
    localparam int BOUND_W         = 5;
    localparam int FRACTION_BITS   = 15;
    localparam int DEF_MAX_TERMS   = 16;
    localparam int DEF_MAX_COLUMNS = 16;

    localparam logic [GRADE_W-1:0] GRADE_ONE  = GRADE_W'(1 << FRACTION_BITS);
    localparam logic [2*GRADE_W-1:0] GRADE_HALF = (2*GRADE_W)'(1 << (FRACTION_BITS - 1));

    // Norm selector codes
    localparam logic [1:0] NORM_MIN  = 2'd0;
    localparam logic [1:0] NORM_PROD = 2'd1;
    localparam logic [1:0] NORM_MAX  = 2'd2;
    localparam logic [1:0] NORM_PSUM = 2'd3;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_ADDR_W-1:0] REG_TNORM_MODE    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SNORM_MODE    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INNER_SIZE    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RESULT_COLS   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DIAGONAL_ONLY = 3'd4;

    // Control broadcast from the sequencer to every column cell
    typedef struct packed {
        logic                 wr_en;
        logic [INDEX_W-1:0]   wr_term;
        logic [INDEX_W-1:0]   wr_col;
        logic [GRADE_W-1:0]   wr_value;
        logic                 rd_en;
        logic [INDEX_W-1:0]   rd_term;
        logic                 t_en;
        logic                 s_en;
        logic                 seed;
        logic [GRADE_W-1:0]   a_value;
        logic [1:0]           tnorm_mode;
        logic [1:0]           snorm_mode;
        logic                 capture;
        logic [BOUND_W-1:0]   cols;
        logic                 diag;
        logic [ROW_W-1:0]     row;
        logic                 shift;
    } cell_ctrl_t;

    // Clamp a grade to one
    function automatic logic [GRADE_W-1:0] sat_grade(input logic [GRADE_W:0] v);
        logic [GRADE_W-1:0] r;
        if (v > {1'b0, GRADE_ONE}) begin
            r = GRADE_ONE;
        end else begin
            r = v[GRADE_W-1:0];
        end
        return r;
    endfunction

    // Product rounded half up
    function automatic logic [GRADE_W-1:0] grade_prod(input logic [GRADE_W-1:0] x,
                                                      input logic [GRADE_W-1:0] y);
        logic [2*GRADE_W-1:0] p;
        p = (2*GRADE_W)'(x) * (2*GRADE_W)'(y) + GRADE_HALF;
        return sat_grade(p[FRACTION_BITS +: GRADE_W+1]);
    endfunction

    // One T-norm or S-norm evaluation
    function automatic logic [GRADE_W-1:0] apply_norm(input logic [1:0]         mode,
                                                      input logic [GRADE_W-1:0] x,
                                                      input logic [GRADE_W-1:0] y);
        logic [GRADE_W-1:0] p;
        logic [GRADE_W:0]   s;
        logic [GRADE_W-1:0] r;
        p = grade_prod(x, y);
        s = {1'b0, x} + {1'b0, y} - {1'b0, p};
        case (mode)
            NORM_MIN:  r = (x < y) ? x : y;
            NORM_PROD: r = p;
            NORM_MAX:  r = (x > y) ? x : y;
            NORM_PSUM: r = sat_grade(s);
            default:   r = p;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/fnc_cell.sv */
// ----------------------------------------------------------------------------
// fnc_cell
// One result column: its column of B, the T-norm and S-norm stages, the
// accumulator and one stage of the result unload chain.
// ----------------------------------------------------------------------------
module fnc_cell #(
    parameter int TERMS_CAP  = fnc_pkg::DEF_MAX_TERMS,
    parameter int CELL_INDEX = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  fnc_pkg::cell_ctrl_t          ctrl,
    input  logic                         chain_valid_in,
    input  logic [fnc_pkg::GRADE_W-1:0]  chain_value_in,
    input  logic [fnc_pkg::INDEX_W-1:0]  chain_col_in,
    output logic                         chain_valid_out,
    output logic [fnc_pkg::GRADE_W-1:0]  chain_value_out,
    output logic [fnc_pkg::INDEX_W-1:0]  chain_col_out
);
    import fnc_pkg::*;

    localparam int ADDR_W = (TERMS_CAP > 1) ? $clog2(TERMS_CAP) : 1;

    logic [GRADE_W-1:0] b_mem [TERMS_CAP];
    logic [GRADE_W-1:0] rd_data_reg;
    logic [GRADE_W-1:0] t_reg;
    logic [GRADE_W-1:0] acc_reg, acc_next;
    logic               valid_reg, valid_next;
    logic [GRADE_W-1:0] value_reg, value_next;
    logic [INDEX_W-1:0] col_reg, col_next;
    logic               wr_hit;
    logic               active;
    logic               keep;

    // Store the B entry of this column
    assign wr_hit = ctrl.wr_en && (ctrl.wr_col == INDEX_W'(CELL_INDEX))
                    && ({1'b0, ctrl.wr_term} < (INDEX_W+1)'(TERMS_CAP));

    always_ff @(posedge aclk) begin
        if (wr_hit) begin
            b_mem[ctrl.wr_term[ADDR_W-1:0]] <= ctrl.wr_value;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= b_mem[ctrl.rd_term[ADDR_W-1:0]];
        end
    end

    // T-norm of the streamed grade and the stored entry
    always_ff @(posedge aclk) begin
        if (ctrl.t_en) begin
            t_reg <= apply_norm(ctrl.tnorm_mode, ctrl.a_value, rd_data_reg);
        end
    end

    // Only columns inside the result width take part in a transaction
    assign active = ((BOUND_W)'(CELL_INDEX) < ctrl.cols);

    // Seed or fold the accumulator
    always_comb begin
        acc_next = acc_reg;
        if (ctrl.s_en && active) begin
            acc_next = ctrl.seed ? t_reg : apply_norm(ctrl.snorm_mode, acc_reg, t_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    // Load the unload chain from the accumulator, or advance it by one cell
    assign keep = active && (!ctrl.diag || (ctrl.row == ROW_W'(CELL_INDEX)));

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        col_next   = col_reg;
        if (ctrl.capture) begin
            valid_next = keep;
            value_next = acc_reg;
            col_next   = INDEX_W'(CELL_INDEX);
        end else if (ctrl.shift) begin
            valid_next = chain_valid_in;
            value_next = chain_value_in;
            col_next   = chain_col_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
        col_reg   <= col_next;
    end

    assign chain_valid_out = valid_reg;
    assign chain_value_out = value_reg;
    assign chain_col_out   = col_reg;

endmodule

/* rtl/core/fuzzy_norm_composition.sv */
// ----------------------------------------------------------------------------
// fuzzy_norm_composition
// Load transaction: written straight into B, and the next one is taken in the following cycle.
// Stream transaction: B read, T-norm stage, S-norm stage of the cells, in that order.
// Last term: the cells then capture into the unload chain, which shifts one cell a
// cycle toward the output while m_tready is not low; m_tready low stalls it.
// Reset clears control, configuration and accumulators; B is undefined until written.
// ----------------------------------------------------------------------------
module fuzzy_norm_composition #(
    parameter int MAX_TERMS   = fnc_pkg::DEF_MAX_TERMS,
    parameter int MAX_COLUMNS = fnc_pkg::DEF_MAX_COLUMNS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [39:0]                     s_tdata,  // row_index, term_index, column_index, value
    input  logic [0:0]                      s_tuser,  // command
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [39:0]                     m_tdata,  // out_row, out_column, out_value, zero pad
    output logic                            m_tlast,
    // Configuration
    input  logic                            cfg_wr_en,
    input  logic [fnc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [fnc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import fnc_pkg::*;

    `include "fuzzy_norm_composition_macros.svh"

    localparam int TERMS_CAP = (MAX_TERMS < FIELD_CAP) ? MAX_TERMS : FIELD_CAP;
    localparam int COLS_CAP  = (MAX_COLUMNS < FIELD_CAP) ? MAX_COLUMNS : FIELD_CAP;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_TNORM   = 5'b00010,
        ST_SNORM   = 5'b00100,
        ST_CAPTURE = 5'b01000,
        ST_DRAIN   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]         tnorm_reg, snorm_reg;
    logic [BOUND_W-1:0] inner_reg, cols_reg;
    logic               diag_reg;

    logic [GRADE_W-1:0] a_reg;
    logic [ROW_W-1:0]   row_reg;
    logic               seed_reg, last_reg;

    logic               in_cmd;
    logic [ROW_W-1:0]   in_row;
    logic [INDEX_W-1:0] in_term;
    logic [INDEX_W-1:0] in_col;
    logic [GRADE_W-1:0] in_value;
    logic [GRADE_W-1:0] in_grade;
    logic               s_accept;
    logic               stream_go;

    logic [BOUND_W-1:0] terms_eff, cols_eff;
    cell_ctrl_t         ctrl;

    logic [COLS_CAP-1:0] chain_valid;
    logic [GRADE_W-1:0]  chain_value [COLS_CAP];
    logic [INDEX_W-1:0]  chain_col   [COLS_CAP];

    // Unpack the input transaction
    assign in_cmd   = s_tuser[0];
    assign in_row   = s_tdata[15:0];
    assign in_term  = s_tdata[19:16];
    assign in_col   = s_tdata[23:20];
    assign in_value = s_tdata[39:24];
    assign in_grade = sat_grade({1'b0, in_value});

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Clamp the size registers to the built array, a zero size counting as one
    always_comb begin
        if (inner_reg == '0) begin
            terms_eff = BOUND_W'(1);
        end else if (inner_reg > BOUND_W'(TERMS_CAP)) begin
            terms_eff = BOUND_W'(TERMS_CAP);
        end else begin
            terms_eff = inner_reg;
        end
        if (cols_reg == '0) begin
            cols_eff = BOUND_W'(1);
        end else if (cols_reg > BOUND_W'(COLS_CAP)) begin
            cols_eff = BOUND_W'(COLS_CAP);
        end else begin
            cols_eff = cols_reg;
        end
    end

    assign stream_go = s_accept && in_cmd && ({1'b0, in_term} < terms_eff);

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tnorm_reg <= NORM_MIN;
            snorm_reg <= NORM_MAX;
            inner_reg <= BOUND_W'(FIELD_CAP);
            cols_reg  <= BOUND_W'(FIELD_CAP);
            diag_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_TNORM_MODE:    tnorm_reg <= cfg_wdata[1:0];
                REG_SNORM_MODE:    snorm_reg <= cfg_wdata[1:0];
                REG_INNER_SIZE:    inner_reg <= cfg_wdata[BOUND_W-1:0];
                REG_RESULT_COLS:   cols_reg  <= cfg_wdata[BOUND_W-1:0];
                REG_DIAGONAL_ONLY: diag_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Hold the fields of the streamed element
    always_ff @(posedge aclk) begin
        if (stream_go) begin
            a_reg    <= in_grade;
            row_reg  <= in_row;
            seed_reg <= (in_term == '0);
            last_reg <= ({1'b0, in_term} == (terms_eff - BOUND_W'(1)));
        end
    end

    // Sequence one transaction through the cells
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (stream_go) state_next = ST_TNORM;
            ST_TNORM:   state_next = ST_SNORM;
            ST_SNORM:   state_next = last_reg ? ST_CAPTURE : ST_IDLE;
            ST_CAPTURE: state_next = ST_DRAIN;
            ST_DRAIN:   if (chain_valid == '0) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Broadcast control to the column cells
    always_comb begin
        ctrl            = '0;
        ctrl.wr_en      = s_accept && !in_cmd;
        ctrl.wr_term    = in_term;
        ctrl.wr_col     = in_col;
        ctrl.wr_value   = in_grade;
        ctrl.rd_en      = stream_go;
        ctrl.rd_term    = in_term;
        ctrl.t_en       = (state_reg == ST_TNORM);
        ctrl.s_en       = (state_reg == ST_SNORM);
        ctrl.seed       = seed_reg;
        ctrl.a_value    = a_reg;
        ctrl.tnorm_mode = tnorm_reg;
        ctrl.snorm_mode = snorm_reg;
        ctrl.capture    = (state_reg == ST_CAPTURE);
        ctrl.cols       = cols_eff;
        ctrl.diag       = diag_reg;
        ctrl.row        = row_reg;
        ctrl.shift      = (state_reg == ST_DRAIN) && (!chain_valid[0] || m_tready);
    end

    // Row of column cells, unloading toward cell zero
    for (genvar j = 0; j < COLS_CAP; j++) begin : g_cell
        logic               nb_valid;
        logic [GRADE_W-1:0] nb_value;
        logic [INDEX_W-1:0] nb_col;

        if (j == COLS_CAP - 1) begin : g_tail
            assign nb_valid = 1'b0;
            assign nb_value = '0;
            assign nb_col   = '0;
        end else begin : g_link
            assign nb_valid = chain_valid[j+1];
            assign nb_value = chain_value[j+1];
            assign nb_col   = chain_col[j+1];
        end

        fnc_cell #(
            .TERMS_CAP  (TERMS_CAP),
            .CELL_INDEX (j)
        ) u_cell (
            .aclk            (aclk),
            .aresetn         (aresetn),
            .ctrl            (ctrl),
            .chain_valid_in  (nb_valid),
            .chain_value_in  (nb_value),
            .chain_col_in    (nb_col),
            .chain_valid_out (chain_valid[j]),
            .chain_value_out (chain_value[j]),
            .chain_col_out   (chain_col[j])
        );
    end

    // Present the head of the chain
    assign m_tvalid = chain_valid[0];
    assign m_tlast  = chain_valid[0] && ((chain_valid >> 1) == '0);
    assign m_tdata  = {4'b0000, chain_value[0], chain_col[0], row_reg};

    `FNC_ASSERT(a_no_accept_while_unloading, !(s_tready && m_tvalid), "input taken during unload")
    `FNC_ASSERT(a_diag_single, !(diag_reg && (state_reg == ST_DRAIN)) || ($countones(chain_valid) <= 1), "diagonal mode holds several results")
    `FNC_ASSERT_NEXT(a_last_ends_run, m_tvalid && m_tready && m_tlast, !m_tvalid, "result after last of run")
    `FNC_ASSERT_NEXT(a_snorm_follows_tnorm, state_reg == ST_TNORM, state_reg == ST_SNORM && !s_tready, "fold stage skipped")

endmodule
